/* rtl/lgrs_pkg.sv */
// shared constants for the row-streaming life generation step
// no dependencies
`default_nettype none

package lgrs_pkg;

	localparam int CELLS_W        = 64;
	localparam int ROW_NUM_W      = 10;
	localparam int GRID_W_W       = 7;
	localparam int IN_DATA_W      = 64;
	localparam int OUT_DATA_W     = 80;
	localparam int APB_ADDR_W     = 3;
	localparam int APB_DATA_W     = 32;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_ROWS_DEF   = 1024;

	localparam logic [GRID_W_W-1:0] COL_COUNT_RESET = 7'd64;

	// register word index
	localparam logic REG_COL_COUNT = 1'b0;

endpackage

`default_nettype wire

/* rtl/life_generation_row_step.sv */
// one generation of the b3/s23 automaton, streamed one grid row per transaction
// uses lgrs_pkg; apb register col_count at byte address 0
// a result passes the operand stage and then the output register before it is on m_tdata
// throughput: one row per cycle while m_tready keeps the output moving; a final row after
//   earlier rows produces two results and holds the input side until the first is in the output register
// the output register lets the next row be taken while a result waits
// reset (async, active low) clears row history, row counter and pending results;
//   col_count returns to 64
`default_nettype none

module life_generation_row_step
	import lgrs_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_ROWS  = MAX_ROWS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input rows
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // [63:0] row_cells
	input  wire logic                  s_tlast,  // final_row
	// result rows
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // [63:0] next_cells, [73:64] row_number,
	                                             // [74] row_alive, [75] row_changed, [79:76] zero
	output logic                       m_tlast,  // last
	// configuration
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int MW = MAX_WIDTH;
	localparam int CW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [CW-1:0] CNT_LAST = CW'(MAX_ROWS - 1);
	localparam logic [GRID_W_W-1:0] MW_CODE = GRID_W_W'(MAX_WIDTH);

	// ---------------- configuration ----------------
	logic [GRID_W_W-1:0] col_count_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= COL_COUNT_RESET;
		end else if (cfg_wr && (paddr[2] == REG_COL_COUNT)) begin
			col_count_q <= pwdata[GRID_W_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_COL_COUNT) begin
			prdata[GRID_W_W-1:0] = col_count_q;
		end
	end

	// column mask from the clamped width
	logic [GRID_W_W-1:0] eff_w;
	logic [MW-1:0]       col_mask;

	always_comb begin
		if (col_count_q == '0) begin
			eff_w = GRID_W_W'(1);
		end else if (col_count_q > MW_CODE) begin
			eff_w = MW_CODE;
		end else begin
			eff_w = col_count_q;
		end
	end

	for (genvar x = 0; x < MW; x++) begin : g_mask
		assign col_mask[x] = (GRID_W_W'(x) < eff_w);
	end

	// ---------------- row history ----------------
	logic [MW-1:0] upper_q;
	logic [MW-1:0] middle_q;
	logic          held_q;
	logic [CW-1:0] count_q;

	logic          in_acc;
	logic [MW-1:0] cur_row;

	assign in_acc  = s_tvalid && s_tready;
	assign cur_row = s_tdata[MW-1:0] & col_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= '0;
			middle_q <= '0;
			held_q   <= 1'b0;
			count_q  <= '0;
		end else if (in_acc) begin
			if (s_tlast) begin
				// end of generation
				upper_q  <= '0;
				middle_q <= '0;
				held_q   <= 1'b0;
				count_q  <= '0;
			end else begin
				upper_q  <= held_q ? middle_q : '0;
				middle_q <= cur_row;
				held_q   <= 1'b1;
				count_q  <= (count_q == CNT_LAST) ? '0 : count_q + CW'(1);
			end
		end
	end

	// ---------------- operand stage ----------------
	// pa: result for the held middle row, pb: result for the final row itself
	logic          pa_s1, pb_s1;
	logic [MW-1:0] up_s1, mid_s1, cur_s1;
	logic [CW-1:0] idx_s1;
	logic          out_load;

	assign s_tready = !(pa_s1 || pb_s1) || (out_load && !(pa_s1 && pb_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_s1 <= 1'b0;
			pb_s1 <= 1'b0;
		end else if (in_acc) begin
			pa_s1 <= held_q;
			pb_s1 <= s_tlast;
		end else if (out_load) begin
			if (pa_s1) begin
				pa_s1 <= 1'b0;
			end else begin
				pb_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			up_s1  <= upper_q;
			mid_s1 <= held_q ? middle_q : '0;
			cur_s1 <= cur_row;
			idx_s1 <= count_q;
		end
	end

	// ---------------- neighbor counting ----------------
	logic [MW-1:0] op_above, op_row, op_below;
	logic [MW+1:0] ab_ext, rw_ext, bl_ext;
	logic [MW-1:0] nxt_raw, nxt_row, old_row;
	logic [CW-1:0] res_idx;

	always_comb begin
		if (pa_s1) begin
			op_above = up_s1;
			op_row   = mid_s1;
			op_below = cur_s1;
			res_idx  = (idx_s1 == '0) ? CNT_LAST : idx_s1 - CW'(1);
		end else begin
			op_above = mid_s1;
			op_row   = cur_s1;
			op_below = '0;
			res_idx  = idx_s1;
		end
	end

	// dead column on each side
	assign ab_ext = {1'b0, op_above & col_mask, 1'b0};
	assign rw_ext = {1'b0, op_row & col_mask, 1'b0};
	assign bl_ext = {1'b0, op_below & col_mask, 1'b0};
	assign old_row = op_row & col_mask;

	for (genvar x = 0; x < MW; x++) begin : g_cell
		logic [3:0] nbr;
		assign nbr = 4'(ab_ext[x]) + 4'(ab_ext[x+1]) + 4'(ab_ext[x+2])
		           + 4'(rw_ext[x]) + 4'(rw_ext[x+2])
		           + 4'(bl_ext[x]) + 4'(bl_ext[x+1]) + 4'(bl_ext[x+2]);
		assign nxt_raw[x] = (nbr == 4'd3) || (rw_ext[x+1] && (nbr == 4'd2));
	end

	assign nxt_row = nxt_raw & col_mask;

	// ---------------- output register ----------------
	logic [MW-1:0]        out_cells_q;
	logic [ROW_NUM_W-1:0] out_num_q;
	logic                 out_alive_q, out_changed_q, out_last_q;
	logic                 m_valid_q;
	logic [CW+ROW_NUM_W-1:0] idx_ext;

	assign idx_ext  = {{ROW_NUM_W{1'b0}}, res_idx};
	assign out_load = (pa_s1 || pb_s1) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cells_q   <= nxt_row;
			out_num_q     <= idx_ext[ROW_NUM_W-1:0];
			out_alive_q   <= |nxt_row;
			out_changed_q <= (nxt_row != old_row);
			out_last_q    <= !pa_s1;
		end
	end

	logic [CELLS_W-1:0] cells_ext;

	always_comb begin
		cells_ext = '0;
		cells_ext[MW-1:0] = out_cells_q;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, out_changed_q, out_alive_q, out_num_q, cells_ext};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// testbench for life_generation_row_step: streams grids row by row over the input bus
// and checks every next-generation row against a behavioral model kept here
// depends on lgrs_pkg and the life_generation_row_step rtl
module tb_top;
	import lgrs_pkg::*;

	localparam int IDLE_LIMIT  = 400;
	localparam int MAX_SHOWN   = 10;
	localparam int ROW_TARGET  = 1300;
	localparam int SETTLE_CYC  = 4;
	localparam logic [APB_ADDR_W-1:0] COL_COUNT_ADDR = {REG_COL_COUNT, 2'b00};

	typedef struct {
		logic [CELLS_W-1:0]   cells;
		logic [ROW_NUM_W-1:0] row_num;
		logic                 alive;
		logic                 changed;
		logic                 last_row;
	} life_row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	life_generation_row_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// model state
	logic [GRID_W_W-1:0]  width_reg = COL_COUNT_RESET;
	logic [CELLS_W-1:0]   upper_cells = '0;
	logic [CELLS_W-1:0]   middle_cells = '0;
	int                   rows_held = 0;
	logic [ROW_NUM_W-1:0] next_row_num = '0;
	life_row_t            pending_rows[$];

	int src_gap_max  = 0;
	int sink_gap_max = 0;
	int rows_sent    = 0;
	int rows_checked = 0;
	int grids_done   = 0;
	int width_writes = 0;
	int failures     = 0;
	int quiet_cycles = 0;

	function automatic int active_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return int'(width_reg);
	endfunction

	function automatic logic [CELLS_W-1:0] column_mask(input int w);
		if (w >= CELLS_W)
			return '1;
		return (64'd1 << w) - 64'd1;
	endfunction

	function automatic logic [CELLS_W-1:0] evolve(input logic [CELLS_W-1:0] above,
			input logic [CELLS_W-1:0] row, input logic [CELLS_W-1:0] below, input int w);
		logic [CELLS_W-1:0] res;
		int n;
		int xx;
		res = '0;
		for (int x = 0; x < w; x++) begin
			n = 0;
			for (int dx = -1; dx <= 1; dx++) begin
				xx = x + dx;
				if (xx >= 0 && xx < w) begin
					n += above[xx] + below[xx];
					if (dx != 0)
						n += row[xx];
				end
			end
			if (row[x] ? (n == 2 || n == 3) : (n == 3))
				res[x] = 1'b1;
		end
		return res;
	endfunction

	function automatic life_row_t make_result(input logic [CELLS_W-1:0] above,
			input logic [CELLS_W-1:0] row, input logic [CELLS_W-1:0] below,
			input logic [ROW_NUM_W-1:0] num, input int w, input logic fin);
		life_row_t r;
		logic [CELLS_W-1:0] mask;
		logic [CELLS_W-1:0] old;
		mask       = column_mask(w);
		old        = row & mask;
		r.cells    = evolve(above & mask, old, below & mask, w) & mask;
		r.row_num  = num;
		r.alive    = (r.cells != '0);
		r.changed  = (r.cells != old);
		r.last_row = fin;
		return r;
	endfunction

	function automatic void clear_grid();
		upper_cells  = '0;
		middle_cells = '0;
		rows_held    = 0;
		next_row_num = '0;
		grids_done++;
	endfunction

	// advance the model by one accepted row and queue the rows it releases
	function automatic void predict_row(input logic [CELLS_W-1:0] cells, input logic fin);
		int w;
		logic [CELLS_W-1:0] cur;
		w   = active_width();
		cur = cells & column_mask(w);
		if (rows_held == 0) begin
			if (fin) begin
				pending_rows.push_back(make_result('0, cur, '0, '0, w, 1'b1));
				clear_grid();
			end else begin
				upper_cells  = '0;
				middle_cells = cur;
				rows_held    = 1;
				next_row_num = ROW_NUM_W'(1);
			end
		end else begin
			pending_rows.push_back(make_result(upper_cells, middle_cells, cur,
				next_row_num - 1'b1, w, 1'b0));
			upper_cells  = middle_cells;
			middle_cells = cur;
			rows_held    = 2;
			if (fin) begin
				pending_rows.push_back(make_result(upper_cells, middle_cells, '0,
					next_row_num, w, 1'b1));
				clear_grid();
			end else begin
				next_row_num = next_row_num + 1'b1;
			end
		end
	endfunction

	task automatic send_row(input logic [CELLS_W-1:0] cells, input logic fin);
		int gap;
		gap = $urandom_range(src_gap_max, 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= cells;
		s_tlast  <= fin;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_row(cells, fin);
		rows_sent++;
	endtask

	// drop valid and let every expected result drain before touching the register
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_rows.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_width(input logic [GRID_W_W-1:0] w);
		logic [APB_DATA_W-1:0] word;
		wait_idle();
		word        = $urandom;
		word[GRID_W_W-1:0] = w;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= COL_COUNT_ADDR;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		width_reg = w;
		width_writes++;
	endtask

	function automatic logic [CELLS_W-1:0] pick_row(input int style,
			input logic [CELLS_W-1:0] prev);
		logic [CELLS_W-1:0] a;
		logic [CELLS_W-1:0] b;
		logic [CELLS_W-1:0] c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case (style)
			0:       return a & b & c;
			1:       return a;
			2:       return a | b;
			3:       return ($urandom_range(1, 0) == 1) ? prev : a & b;
			default: return ($urandom_range(1, 0) == 1) ? '0 : '1;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [CELLS_W-1:0] want,
			input logic [CELLS_W-1:0] got, input logic [ROW_NUM_W-1:0] num);
		if (want !== got) begin
			failures++;
			if (failures <= MAX_SHOWN)
				$display("mismatch row %0d %s: expected %h, got %h", num, name, want, got);
		end
	endtask

	// result checking and watchdog
	always @(posedge clk) begin
		life_row_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				rows_checked++;
				if (pending_rows.size() == 0) begin
					failures++;
					if (failures <= MAX_SHOWN)
						$display("unexpected result transaction: %h last %b", m_tdata, m_tlast);
				end else begin
					want = pending_rows.pop_front();
					check_field("next_cells", want.cells, m_tdata[63:0], want.row_num);
					check_field("row_number", 64'(want.row_num), 64'(m_tdata[73:64]),
						want.row_num);
					check_field("row_alive", 64'(want.alive), 64'(m_tdata[74]), want.row_num);
					check_field("row_changed", 64'(want.changed), 64'(m_tdata[75]),
						want.row_num);
					check_field("last", 64'(want.last_row), 64'(m_tlast), want.row_num);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// result sink with random stalls
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = $urandom_range(sink_gap_max, 0);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic test_single_row_grids();
		send_row('1, 1'b1);
		send_row('0, 1'b1);
		send_row(64'h5555_5555_5555_5555, 1'b1);
	endtask

	// 2x2 blocks against both side walls stay put
	task automatic test_still_life();
		write_width(7'd64);
		send_row('0, 1'b0);
		send_row(64'hC000_0000_0000_0003, 1'b0);
		send_row(64'hC000_0000_0000_0003, 1'b0);
		send_row('0, 1'b1);
	endtask

	task automatic test_narrow_widths();
		write_width(7'd0);
		repeat (2) send_row('1, 1'b0);
		send_row('1, 1'b1);
		// vertical blinker, dead bits above the width set on purpose
		write_width(7'd3);
		repeat (2) send_row(64'hFFFF_FFFF_FFFF_FFFA, 1'b0);
		send_row(64'hFFFF_FFFF_FFFF_FFFA, 1'b1);
	endtask

	task automatic test_oversize_width();
		write_width(7'd127);
		send_row('1, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b0);
		send_row('1, 1'b1);
	endtask

	task automatic test_width_change_mid_grid();
		write_width(7'd10);
		send_row({$urandom, $urandom}, 1'b0);
		write_width(7'd40);
		send_row({$urandom, $urandom}, 1'b0);
		send_row({$urandom, $urandom}, 1'b1);
	endtask

	// one tall grid at full rate so the row number wraps
	task automatic test_row_number_wrap();
		logic [CELLS_W-1:0] row;
		write_width(7'd64);
		src_gap_max  = 0;
		sink_gap_max = 0;
		row = '0;
		for (int i = 0; i < MAX_ROWS_DEF + 6; i++) begin
			row = pick_row($urandom_range(4, 0), row);
			send_row(row, i == MAX_ROWS_DEF + 5);
		end
	endtask

	task automatic test_random_grids();
		int height;
		int style;
		int pick;
		logic [CELLS_W-1:0] row;
		while (rows_sent < ROW_TARGET) begin
			if ($urandom_range(1, 0) == 1) begin
				pick = $urandom_range(9, 0);
				case (pick)
					0:       write_width(7'd0);
					1:       write_width(7'd1);
					2:       write_width(7'd64);
					3:       write_width(7'($urandom_range(127, 65)));
					default: write_width(7'($urandom_range(64, 2)));
				endcase
			end
			src_gap_max  = ($urandom_range(3, 0) == 0) ? 0 : 11;
			sink_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 11;
			height = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
			style  = $urandom_range(4, 0);
			row    = '0;
			for (int i = 0; i < height; i++) begin
				row = pick_row(($urandom_range(4, 0) == 0) ? $urandom_range(4, 0) : style, row);
				send_row(row, i == height - 1);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_gap_max  = 11;
		sink_gap_max = 11;
		test_single_row_grids();
		test_still_life();
		test_narrow_widths();
		test_oversize_width();
		test_width_change_mid_grid();
		test_row_number_wrap();
		test_random_grids();
		s_tvalid <= 1'b0;
		while (pending_rows.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		failures += pending_rows.size();
		$display("covered %0d rows in %0d grids, %0d result rows checked", rows_sent,
			grids_done, rows_checked);
		$display("%0d width writes, widths from 0 through 127, row number wrap included",
			width_writes);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/lgrs_pkg.sv
rtl/life_generation_row_step.sv
sim/tb_top.sv
